// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, masked while reset is asserted.
`define PTIK_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Signal holds while a result transaction is stalled.
`define PTIK_HOLD(label, sig, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) \
    (out_valid && out_stall) |=> $stable(sig)) else $error(msg);

`endif

// ===== rtl/ptik_pkg.sv =====
// Types, constants and tables for the pan/tilt inverse kinematics core.
package ptik_pkg;

  localparam int DW       = 45;
  localparam int ZW       = 24;
  localparam int CORDIC_N = 20;

  typedef logic signed [DW-1:0] dat_t;
  typedef logic signed [ZW-1:0] ang_t;

  localparam ang_t PI_Q20      = 24'sd3294199;
  localparam ang_t HALF_PI_Q20 = 24'sd1647099;
  localparam dat_t GAIN_INV    = 45'sd652032874;
  localparam logic [23:0] GRIP_MUL = 24'd14055248;
  localparam logic [14:0] PCT_MAX  = 15'd25600;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_RANGE = 2'd1;
  localparam logic [1:0] STATUS_JOINT = 2'd2;

  localparam logic [2:0] CFG_BASE_HEIGHT     = 3'd0;
  localparam logic [2:0] CFG_SHOULDER_OFFSET = 3'd1;
  localparam logic [2:0] CFG_LINK_LENGTH     = 3'd2;
  localparam logic [2:0] CFG_TOOL_OFFSET     = 3'd3;
  localparam logic [2:0] CFG_REACH_RADIUS    = 3'd4;
  localparam logic [2:0] CFG_PAN_LIMIT       = 3'd5;
  localparam logic [2:0] CFG_TILT_UPPER      = 3'd6;
  localparam logic [2:0] CFG_TILT_LOWER      = 3'd7;

  localparam logic [15:0] RST_BASE_HEIGHT     = 16'd2949;
  localparam logic [15:0] RST_SHOULDER_OFFSET = 16'd3932;
  localparam logic [15:0] RST_LINK_LENGTH     = 16'd4260;
  localparam logic [15:0] RST_TOOL_OFFSET     = 16'd4588;
  localparam logic [15:0] RST_REACH_RADIUS    = 16'd6260;
  localparam logic [14:0] RST_PAN_LIMIT       = 15'd21430;
  localparam logic [15:0] RST_TILT_UPPER      = 16'd6554;
  localparam logic [15:0] RST_TILT_LOWER      = 16'hC000;

  typedef struct packed {
    logic              oor;
    logic              xzero;
    logic              spec;
    logic              tzero;
    logic              neg;
    logic signed [18:0] yb;
    logic signed [18:0] zb;
    logic [14:0]       grip;
    logic signed [15:0] pan;
  } side_t;

  typedef struct packed {
    logic  vec;
    dat_t  x;
    dat_t  y;
    ang_t  z;
    side_t side;
  } crd_t;

  function automatic ang_t atan_q20(input logic [4:0] i);
    ang_t a;
    case (i)
      5'd0:  a = 24'sd823550;
      5'd1:  a = 24'sd486170;
      5'd2:  a = 24'sd256879;
      5'd3:  a = 24'sd130396;
      5'd4:  a = 24'sd65451;
      5'd5:  a = 24'sd32757;
      5'd6:  a = 24'sd16383;
      5'd7:  a = 24'sd8192;
      5'd8:  a = 24'sd4096;
      5'd9:  a = 24'sd2048;
      5'd10: a = 24'sd1024;
      5'd11: a = 24'sd512;
      5'd12: a = 24'sd256;
      5'd13: a = 24'sd128;
      5'd14: a = 24'sd64;
      5'd15: a = 24'sd32;
      5'd16: a = 24'sd16;
      5'd17: a = 24'sd8;
      5'd18: a = 24'sd4;
      5'd19: a = 24'sd2;
      default: a = '0;
    endcase
    return a;
  endfunction

  // True when -2^t < v < 2^t.
  function automatic logic fits(input dat_t v, input logic [5:0] t);
    dat_t lim;
    lim = dat_t'(1) <<< t;
    return (v < lim) && (v > -lim);
  endfunction

endpackage

// ===== rtl/pan_tilt_inverse_kinematics_core.sv =====
// Throughput: one transaction per cycle while the result is not stalled; three 20-cell CORDIC
// rows (pan atan2, cos, tilt atan2) and two 7-stage normalizers form one pipeline that advances
// whenever it is not stalled. A stalled result holds the whole pipeline and raises in_stall.
// Reset (synchronous, rst_n low) empties the pipeline and loads the default configuration.
module pan_tilt_inverse_kinematics_core import ptik_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [17:0] in_target_x,
  input  logic signed [17:0] in_target_y,
  input  logic signed [17:0] in_target_z,
  input  logic [14:0]        in_finger_percent,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic signed [15:0] out_pan_angle,
  output logic signed [15:0] out_tilt_angle,
  output logic [14:0]        out_gripper_angle
);

  // configuration registers
  logic [15:0] base_height_r, shoulder_offset_r, link_length_r, tool_offset_r;
  logic [15:0] reach_radius_r, tilt_upper_r, tilt_lower_r;
  logic [14:0] pan_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_height_r     <= RST_BASE_HEIGHT;
      shoulder_offset_r <= RST_SHOULDER_OFFSET;
      link_length_r     <= RST_LINK_LENGTH;
      tool_offset_r     <= RST_TOOL_OFFSET;
      reach_radius_r    <= RST_REACH_RADIUS;
      pan_limit_r       <= RST_PAN_LIMIT;
      tilt_upper_r      <= RST_TILT_UPPER;
      tilt_lower_r      <= RST_TILT_LOWER;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BASE_HEIGHT:     base_height_r     <= cfg_data;
        CFG_SHOULDER_OFFSET: shoulder_offset_r <= cfg_data;
        CFG_LINK_LENGTH:     link_length_r     <= cfg_data;
        CFG_TOOL_OFFSET:     tool_offset_r     <= cfg_data;
        CFG_REACH_RADIUS:    reach_radius_r    <= cfg_data;
        CFG_PAN_LIMIT:       pan_limit_r       <= cfg_data[14:0];
        CFG_TILT_UPPER:      tilt_upper_r      <= cfg_data;
        CFG_TILT_LOWER:      tilt_lower_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  logic en;
  logic out_valid_r;
  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  // ---------------- stage 0: box check, offsets, gripper ----------------
  logic signed [19:0] x20, y20, z20, r20, d0s, d1s;
  logic               oor;
  logic signed [19:0] zb20, yb20;
  logic [14:0]        pct_sat;
  logic [38:0]        grip_prod;
  crd_t               s0_nxt, s0_r;
  logic               s0_vld_r;

  always_comb begin
    x20  = 20'(in_target_x);
    y20  = 20'(in_target_y);
    z20  = 20'(in_target_z);
    r20  = signed'({4'b0, reach_radius_r});
    d0s  = signed'({4'b0, base_height_r});
    d1s  = signed'({4'b0, shoulder_offset_r});
    oor  = (x20 > r20) || (x20 < -r20) || (y20 > d1s + r20) || (y20 < d1s - r20) ||
           (z20 > d0s + r20) || (z20 < d0s - r20);
    zb20 = d0s - z20;
    yb20 = y20 - d1s;
    pct_sat   = (in_finger_percent > PCT_MAX) ? PCT_MAX : in_finger_percent;
    grip_prod = 39'(pct_sat) * 39'(GRIP_MUL) + 39'(24'h800000);
    s0_nxt.vec        = 1'b1;
    s0_nxt.x          = dat_t'(zb20);
    s0_nxt.y          = dat_t'(-x20);
    s0_nxt.z          = '0;
    s0_nxt.side.oor   = oor;
    s0_nxt.side.xzero = (in_target_x == '0);
    s0_nxt.side.spec  = (in_target_x == '0) && (zb20 == '0);
    s0_nxt.side.tzero = 1'b0;
    s0_nxt.side.neg   = 1'b0;
    s0_nxt.side.yb    = 19'(yb20);
    s0_nxt.side.zb    = 19'(zb20);
    s0_nxt.side.grip  = grip_prod[38:24];
    s0_nxt.side.pan   = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (en) begin
      s0_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_r <= s0_nxt;
    end
  end

  // ---------------- pan atan2 ----------------
  logic pn_vld;
  crd_t pn_d;
  logic [CORDIC_N:0] pa_vld;
  crd_t              pa_d [0:CORDIC_N];

  ptik_norm u_pan_norm (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_vld(s0_vld_r), .in_d(s0_r), .out_vld(pn_vld), .out_d(pn_d)
  );

  assign pa_vld[0] = pn_vld;
  assign pa_d[0]   = pn_d;

  for (genvar i = 0; i < CORDIC_N; i++) begin : g_pan
    ptik_cordic_cell u_cell (
      .clk(clk), .rst_n(rst_n), .en(en), .iter(5'(i)),
      .in_vld(pa_vld[i]), .in_d(pa_d[i]), .out_vld(pa_vld[i+1]), .out_d(pa_d[i+1])
    );
  end

  // ---------------- round pan, reduce for cos ----------------
  ang_t               pz_rnd, pz_cos;
  logic signed [15:0] pan16;
  crd_t               cp_nxt, cp_r;
  logic               cp_vld_r;

  always_comb begin
    pz_rnd = pa_d[CORDIC_N].z + 24'sd64;
    pan16  = pa_d[CORDIC_N].side.xzero ? '0 : 16'(pz_rnd >>> 7);
    pz_cos = ang_t'(pan16) <<< 7;
    cp_nxt = pa_d[CORDIC_N];
    cp_nxt.side.pan = pan16;
    cp_nxt.side.neg = 1'b0;
    if (pz_cos > HALF_PI_Q20) begin
      pz_cos = pz_cos - PI_Q20;
      cp_nxt.side.neg = 1'b1;
    end else if (pz_cos < -HALF_PI_Q20) begin
      pz_cos = pz_cos + PI_Q20;
      cp_nxt.side.neg = 1'b1;
    end
    cp_nxt.vec = 1'b0;
    cp_nxt.x   = GAIN_INV;
    cp_nxt.y   = '0;
    cp_nxt.z   = pz_cos;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cp_vld_r <= 1'b0;
    end else if (en) begin
      cp_vld_r <= pa_vld[CORDIC_N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cp_r <= cp_nxt;
    end
  end

  // ---------------- cos(pan) ----------------
  logic [CORDIC_N:0] co_vld;
  crd_t              co_d [0:CORDIC_N];

  assign co_vld[0] = cp_vld_r;
  assign co_d[0]   = cp_r;

  for (genvar i = 0; i < CORDIC_N; i++) begin : g_cos
    ptik_cordic_cell u_cell (
      .clk(clk), .rst_n(rst_n), .en(en), .iter(5'(i)),
      .in_vld(co_vld[i]), .in_d(co_d[i]), .out_vld(co_vld[i+1]), .out_d(co_d[i+1])
    );
  end

  dat_t               cx_rnd;
  logic signed [17:0] c1_nxt, c1_r;
  side_t              sc_r;
  logic               sc_vld_r;

  always_comb begin
    cx_rnd = (co_d[CORDIC_N].x + dat_t'(8192)) >>> 14;
    if (cx_rnd > dat_t'(65536)) begin
      c1_nxt = 18'sd65536;
    end else if (cx_rnd < -dat_t'(65536)) begin
      c1_nxt = -18'sd65536;
    end else begin
      c1_nxt = 18'(cx_rnd);
    end
    if (co_d[CORDIC_N].side.neg) begin
      c1_nxt = -c1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_vld_r <= 1'b0;
    end else if (en) begin
      sc_vld_r <= co_vld[CORDIC_N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_r <= c1_nxt;
      sc_r <= co_d[CORDIC_N].side;
    end
  end

  // ---------------- tilt operand products ----------------
  logic signed [16:0] a2s, d3s;
  assign a2s = signed'({1'b0, link_length_r});
  assign d3s = signed'({1'b0, tool_offset_r});

  logic signed [36:0] p1_r;
  logic signed [35:0] a2zb_r, d3zb_r, a2zb2_r, d3zb2_r;
  logic signed [53:0] t1_r, t2_r;
  side_t              m1_side_r, m2_side_r;
  logic               m1_vld_r, m2_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_vld_r <= 1'b0;
      m2_vld_r <= 1'b0;
    end else if (en) begin
      m1_vld_r <= sc_vld_r;
      m2_vld_r <= m1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r      <= 37'(c1_r) * 37'(sc_r.yb);
      a2zb_r    <= 36'(a2s) * 36'(sc_r.zb);
      d3zb_r    <= 36'(d3s) * 36'(sc_r.zb);
      m1_side_r <= sc_r;
      t1_r      <= 54'(d3s) * 54'(p1_r);
      t2_r      <= 54'(a2s) * 54'(p1_r);
      a2zb2_r   <= a2zb_r;
      d3zb2_r   <= d3zb_r;
      m2_side_r <= m1_side_r;
    end
  end

  dat_t num, den;
  crd_t m3_nxt, m3_r;
  logic m3_vld_r;

  always_comb begin
    if (m2_side_r.spec) begin
      // straight-down target: tilt from the link offsets alone
      num = -dat_t'(d3s);
      den = dat_t'(a2s);
    end else begin
      num = dat_t'(a2zb2_r) - dat_t'(t1_r >>> 16);
      den = dat_t'(t2_r >>> 16) + dat_t'(d3zb2_r);
    end
    m3_nxt.vec        = 1'b1;
    m3_nxt.x          = den;
    m3_nxt.y          = num;
    m3_nxt.z          = '0;
    m3_nxt.side       = m2_side_r;
    m3_nxt.side.tzero = (num == '0) && (den == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m3_vld_r <= 1'b0;
    end else if (en) begin
      m3_vld_r <= m2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m3_r <= m3_nxt;
    end
  end

  // ---------------- tilt atan2 ----------------
  logic tn_vld;
  crd_t tn_d;
  logic [CORDIC_N:0] ta_vld;
  crd_t              ta_d [0:CORDIC_N];

  ptik_norm u_tilt_norm (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_vld(m3_vld_r), .in_d(m3_r), .out_vld(tn_vld), .out_d(tn_d)
  );

  assign ta_vld[0] = tn_vld;
  assign ta_d[0]   = tn_d;

  for (genvar i = 0; i < CORDIC_N; i++) begin : g_tilt
    ptik_cordic_cell u_cell (
      .clk(clk), .rst_n(rst_n), .en(en), .iter(5'(i)),
      .in_vld(ta_vld[i]), .in_d(ta_d[i]), .out_vld(ta_vld[i+1]), .out_d(ta_d[i+1])
    );
  end

  // ---------------- limits and result register ----------------
  side_t              fs;
  ang_t               tz_rnd;
  logic signed [15:0] tilt16;
  logic signed [16:0] pan17, pl17;
  logic               joint_bad;
  logic [1:0]         status_nxt;
  logic signed [15:0] pan_nxt, tilt_nxt;
  logic [14:0]        grip_nxt;
  logic [1:0]         status_r;
  logic signed [15:0] pan_r, tilt_r;
  logic [14:0]        grip_r;

  always_comb begin
    fs        = ta_d[CORDIC_N].side;
    tz_rnd    = ta_d[CORDIC_N].z + 24'sd64;
    tilt16    = fs.tzero ? '0 : 16'(tz_rnd >>> 7);
    pan17     = 17'(fs.pan);
    pl17      = signed'({2'b0, pan_limit_r});
    joint_bad = (pan17 > pl17) || (pan17 < -pl17) ||
                (tilt16 > signed'(tilt_upper_r)) || (tilt16 < signed'(tilt_lower_r));
    if (fs.oor) begin
      status_nxt = STATUS_RANGE;
      pan_nxt    = '0;
      tilt_nxt   = '0;
      grip_nxt   = '0;
    end else if (joint_bad) begin
      status_nxt = STATUS_JOINT;
      pan_nxt    = fs.pan;
      tilt_nxt   = tilt16;
      grip_nxt   = '0;
    end else begin
      status_nxt = STATUS_OK;
      pan_nxt    = fs.pan;
      tilt_nxt   = tilt16;
      grip_nxt   = fs.grip;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= ta_vld[CORDIC_N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      status_r <= status_nxt;
      pan_r    <= pan_nxt;
      tilt_r   <= tilt_nxt;
      grip_r   <= grip_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_pan_angle     = pan_r;
  assign out_tilt_angle    = tilt_r;
  assign out_gripper_angle = grip_r;

endmodule

// ===== rtl/ptik_cordic_cell.sv =====
// One CORDIC micro-rotation cell, vectoring or rotation mode per transaction.
module ptik_cordic_cell import ptik_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  logic [4:0] iter,
  input  logic       in_vld,
  input  crd_t       in_d,
  output logic       out_vld,
  output crd_t       out_d
);

  logic vld_r;
  crd_t d_r, d_nxt;
  dat_t xs, ys;
  logic go_pos;

  always_comb begin
    xs = in_d.x >>> iter;
    ys = in_d.y >>> iter;
    // vectoring drives y to zero, rotation drives z to zero
    go_pos = in_d.vec ? !in_d.y[DW-1] : in_d.z[ZW-1];
    d_nxt = in_d;
    if (go_pos) begin
      d_nxt.x = in_d.x + ys;
      d_nxt.y = in_d.y - xs;
      d_nxt.z = in_d.z + atan_q20(iter);
    end else begin
      d_nxt.x = in_d.x - ys;
      d_nxt.y = in_d.y + xs;
      d_nxt.z = in_d.z - atan_q20(iter);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign out_vld = vld_r;
  assign out_d   = d_r;

endmodule

// ===== rtl/ptik_norm.sv =====
// Pre-scaler for atan2: left-normalize x/y in binary steps, then fold into the right half plane.
module ptik_norm import ptik_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic in_vld,
  input  crd_t in_d,
  output logic out_vld,
  output crd_t out_d
);

  localparam int STEPS = 6;

  logic [STEPS:0] vld_r;
  crd_t           st_r [0:STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam int AMT = 32 >> k;
    crd_t src, nxt;
    if (k == 0) begin : g_first
      assign src = in_d;
    end else begin : g_rest
      assign src = st_r[k-1];
    end
    always_comb begin
      nxt = src;
      if (fits(src.x, 6'(40 - AMT)) && fits(src.y, 6'(40 - AMT))) begin
        nxt.x = src.x <<< AMT;
        nxt.y = src.y <<< AMT;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        st_r[k] <= nxt;
      end
    end
  end

  crd_t fin_src, fin_nxt;
  assign fin_src = st_r[STEPS-1];

  always_comb begin
    fin_nxt = fin_src;
    fin_nxt.z = '0;
    if (fits(fin_src.x, 6'd40) && fits(fin_src.y, 6'd40)) begin
      fin_nxt.x = fin_src.x <<< 1;
      fin_nxt.y = fin_src.y <<< 1;
    end
    // left half plane: rotate by pi and start the angle there
    if (fin_nxt.x[DW-1]) begin
      fin_nxt.z = fin_nxt.y[DW-1] ? -PI_Q20 : PI_Q20;
      fin_nxt.x = -fin_nxt.x;
      fin_nxt.y = -fin_nxt.y;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[STEPS] <= fin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[STEPS-1:0], in_vld};
    end
  end

  assign out_vld = vld_r[STEPS];
  assign out_d   = st_r[STEPS];

endmodule

// ===== rtl/ptik_checker.sv =====
// Port-level checks on the result channel of the inverse kinematics core.
`include "assert_macros.svh"

module ptik_checker import ptik_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic [1:0]         out_status,
  input logic signed [15:0] out_pan_angle,
  input logic signed [15:0] out_tilt_angle,
  input logic [14:0]        out_gripper_angle
);

  `PTIK_ASSERT(a_valid_hold, (out_valid && out_stall) |=> out_valid, "result dropped while stalled")
  `PTIK_HOLD(a_status_hold, out_status, "status changed while stalled")
  `PTIK_ASSERT(a_status_code, out_valid |-> (out_status == STATUS_OK || out_status == STATUS_RANGE || out_status == STATUS_JOINT), "undefined status code")
  `PTIK_ASSERT(a_range_zero, (out_valid && out_status == STATUS_RANGE) |-> (out_pan_angle == '0 && out_tilt_angle == '0 && out_gripper_angle == '0), "rejected point carries angles")
  `PTIK_ASSERT(a_joint_grip, (out_valid && out_status == STATUS_JOINT) |-> (out_gripper_angle == '0), "gripper set on joint failure")

endmodule

bind pan_tilt_inverse_kinematics_core ptik_checker u_ptik_checker (.*);
